[src/qte_pkg.sv]
// Shared types, constants and the arctangent table for the quaternion to Euler angle core.
`default_nettype none
package qte_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN    = 24;
  localparam int N_STEPS      = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

  // Q.28 terms built from two Q2.14 products need 34 bits; CORDIC adds gain headroom.
  localparam int TERM_W = 34;
  localparam int CW     = 36;

  // Square root of a value up to 2^56 yields 29 bits.
  localparam int SQ_BITS = 29;
  localparam int SQ_W    = 2 * SQ_BITS + 1;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = 2;
  localparam int CNT_W      = 3;

  typedef logic [ANGLE_BITS-1:0] angle_t;

  localparam angle_t HALF_TURN    = angle_t'(1) << (ANGLE_BITS - 1);
  localparam angle_t QUARTER_TURN = angle_t'(1) << (ANGLE_BITS - 2);

  localparam logic signed [TERM_W-1:0] ONE_Q28 = 34'sh0_1000_0000;

  // Rounding constant for the reduction of an angle to 16 bits.
  localparam logic [ANGLE_BITS+16:0] TO16_RND =
      (ANGLE_BITS > 16) ? ((ANGLE_BITS + 17)'(1) << (ANGLE_BITS - 1)) : '0;

  typedef enum logic [1:0] {
    AXIS_ROLL  = 2'd0,
    AXIS_PITCH = 2'd1,
    AXIS_YAW   = 2'd2,
    AXIS_NONE  = 2'd3
  } axis_e;

  typedef enum logic [1:0] {
    OP_ATAN  = 2'd0,
    OP_ASIN  = 2'd1,
    OP_CONST = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    REG_ROLL  = 2'd0,
    REG_PITCH = 2'd1,
    REG_YAW   = 2'd2
  } reg_e;

  typedef struct packed {
    op_e                        op;
    axis_e                      axis;
    logic signed [TERM_W-1:0]   y;
    logic signed [TERM_W-1:0]   x;
    angle_t                     z;
  } item_t;

  typedef struct packed {
    logic [15:0] roll;
    logic [15:0] pitch;
    logic [15:0] yaw;
  } offs_t;

  function automatic angle_t atan_tab(input int i);
    logic [31:0] t;
    logic [32:0] s;
    case (i)
      0:  t = 32'h20000000;
      1:  t = 32'h12E4051E;
      2:  t = 32'h09FB385B;
      3:  t = 32'h051111D4;
      4:  t = 32'h028B0D43;
      5:  t = 32'h0145D7E1;
      6:  t = 32'h00A2F61E;
      7:  t = 32'h00517C55;
      8:  t = 32'h0028BE53;
      9:  t = 32'h00145F2F;
      10: t = 32'h000A2F98;
      11: t = 32'h000517CC;
      12: t = 32'h00028BE6;
      13: t = 32'h000145F3;
      14: t = 32'h0000A2FA;
      15: t = 32'h0000517D;
      16: t = 32'h000028BE;
      17: t = 32'h0000145F;
      18: t = 32'h00000A30;
      19: t = 32'h00000518;
      20: t = 32'h0000028C;
      21: t = 32'h00000146;
      22: t = 32'h000000A3;
      default: t = 32'h00000051;
    endcase
    s = {1'b0, t} + ((33'd1 << (32 - ANGLE_BITS)) >> 1);
    return angle_t'(s >> (32 - ANGLE_BITS));
  endfunction

endpackage
`default_nettype wire

[src/qte_front.sv]
// Front end: accepts quaternions, forms the products and classifies each transaction.
`default_nettype none
module qte_front import qte_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic signed [15:0]       quat_w_i,
  input  wire logic signed [15:0]       quat_x_i,
  input  wire logic signed [15:0]       quat_y_i,
  input  wire logic signed [15:0]       quat_z_i,
  input  wire logic [1:0]               axis_select_i,
  input  wire logic [CNT_W-1:0]         q_cnt_i,
  output logic                          push_o,
  output item_t                         item_o
);

  logic signed [15:0] a0, a1, a2, a3, b0, b1, b2, b3;
  logic signed [31:0] p0_q, p1_q, p2_q, p3_q;
  axis_e              axis_q;
  logic               pv_q;
  logic               accept;

  logic signed [TERM_W-1:0] e0, e1, e2, e3, sum_a, dif_a, sum_b, sin_t, cos_t, sp_t;

  // Pick the operand pairs needed by the selected angle.
  always_comb begin
    a0 = '0; b0 = '0; a1 = '0; b1 = '0; a2 = '0; b2 = '0; a3 = '0; b3 = '0;
    case (axis_e'(axis_select_i))
      AXIS_ROLL: begin
        a0 = quat_w_i; b0 = quat_x_i; a1 = quat_y_i; b1 = quat_z_i;
        a2 = quat_x_i; b2 = quat_x_i; a3 = quat_y_i; b3 = quat_y_i;
      end
      AXIS_PITCH: begin
        a0 = quat_w_i; b0 = quat_y_i; a1 = quat_z_i; b1 = quat_x_i;
      end
      AXIS_YAW: begin
        a0 = quat_w_i; b0 = quat_z_i; a1 = quat_x_i; b1 = quat_y_i;
        a2 = quat_z_i; b2 = quat_z_i; a3 = quat_y_i; b3 = quat_y_i;
      end
      default: begin
      end
    endcase
  end

  assign in_ready_o = ((CNT_W + 1)'(q_cnt_i) + (CNT_W + 1)'(pv_q)) < (CNT_W + 1)'(FIFO_DEPTH);
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p0_q   <= a0 * b0;
      p1_q   <= a1 * b1;
      p2_q   <= a2 * b2;
      p3_q   <= a3 * b3;
      axis_q <= axis_e'(axis_select_i);
    end
  end

  assign e0    = TERM_W'(p0_q);
  assign e1    = TERM_W'(p1_q);
  assign e2    = TERM_W'(p2_q);
  assign e3    = TERM_W'(p3_q);
  assign sum_a = e0 + e1;
  assign dif_a = e0 - e1;
  assign sum_b = e2 + e3;
  assign sin_t = sum_a <<< 1;
  assign sp_t  = dif_a <<< 1;
  assign cos_t = ONE_Q28 - (sum_b <<< 1);

  always_comb begin
    item_o.axis = axis_q;
    item_o.y    = sin_t;
    item_o.x    = cos_t;
    item_o.z    = '0;
    item_o.op   = OP_ATAN;
    case (axis_q)
      AXIS_ROLL, AXIS_YAW: begin
        if (sin_t == '0 && cos_t == '0) begin
          item_o.op = OP_CONST;
        end
      end
      AXIS_PITCH: begin
        item_o.y = sp_t;
        item_o.x = '0;
        if (sp_t >= ONE_Q28) begin
          item_o.op = OP_CONST;
          item_o.z  = QUARTER_TURN;
        end else if (sp_t <= -ONE_Q28) begin
          item_o.op = OP_CONST;
          item_o.z  = angle_t'(0) - QUARTER_TURN;
        end else begin
          item_o.op = OP_ASIN;
        end
      end
      default: begin
        item_o.op = OP_CONST;
      end
    endcase
  end

  assign push_o = pv_q;

  // Entries in the queue plus the one in flight never exceed its depth.
  a_reserve: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((CNT_W + 1)'(q_cnt_i) + (CNT_W + 1)'(pv_q)) <= (CNT_W + 1)'(FIFO_DEPTH))
    else $error("front reserved more queue slots than exist");

endmodule
`default_nettype wire

[src/qte_queue.sv]
// Small queue that decouples the classifying front end from the angle back end.
`default_nettype none
module qte_queue import qte_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire item_t            item_i,
  input  wire logic             pop_i,
  output item_t                 item_o,
  output logic [CNT_W-1:0]      cnt_o
);

  item_t            mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + PTR_W'(1);
      end
      cnt_q <= cnt_q + CNT_W'(push_i) - CNT_W'(pop_i);
    end
  end

  assign item_o = mem_q[rd_q];
  assign cnt_o  = cnt_q;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> cnt_q < CNT_W'(FIFO_DEPTH))
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0)
    else $error("queue underflow");

endmodule
`default_nettype wire

[src/qte_back.sv]
// Back end: square root for pitch, pipelined CORDIC vectoring, offset and output register.
`default_nettype none
module qte_back import qte_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire item_t            head_i,
  input  wire logic             avail_i,
  output logic                  pop_o,
  input  wire offs_t            offs_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [15:0]           angle_o
);

  typedef struct packed {
    op_e   op;
    axis_e axis;
  } tag_t;

  localparam logic [SQ_W-1:0] RAD_ONE = SQ_W'(1) << (2 * SQ_BITS - 2);

  logic adv;
  logic out_valid_q;
  logic [15:0] angle_q;

  // Square stage
  logic                        v0_q;
  item_t                       it0_q;
  logic signed [SQ_BITS-1:0]   s_in;
  logic signed [2*SQ_BITS-1:0] sq_q;

  // Square root stages
  logic               sv_q   [SQ_BITS+1];
  item_t              sit_q  [SQ_BITS+1];
  logic [SQ_W-1:0]    rem_q  [SQ_BITS+1];
  logic [SQ_BITS-1:0] root_q [SQ_BITS+1];

  // CORDIC stages
  logic               cv_q [N_STEPS+1];
  tag_t               ct_q [N_STEPS+1];
  logic signed [CW-1:0] cx_q [N_STEPS+1];
  logic signed [CW-1:0] cy_q [N_STEPS+1];
  angle_t             cz_q [N_STEPS+1];

  item_t              pre_it;
  logic signed [CW-1:0] pre_x, pre_y;

  assign adv   = !out_valid_q || out_ready_i;
  assign pop_o = adv && avail_i;
  assign s_in  = head_i.y[SQ_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q     <= 1'b0;
      sv_q[0]  <= 1'b0;
    end else if (adv) begin
      v0_q     <= avail_i;
      sv_q[0]  <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      it0_q     <= head_i;
      sq_q      <= s_in * s_in;
      sit_q[0]  <= it0_q;
      rem_q[0]  <= RAD_ONE - SQ_W'(unsigned'(sq_q));
      root_q[0] <= '0;
    end
  end

  for (genvar j = 0; j < SQ_BITS; j++) begin : g_sqrt
    localparam int K = SQ_BITS - 1 - j;
    logic [SQ_W-1:0] trial;
    logic            take;
    assign trial = (SQ_W'(root_q[j]) << (K + 1)) + (SQ_W'(1) << (2 * K));
    assign take  = rem_q[j] >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[j+1] <= 1'b0;
      end else if (adv) begin
        sv_q[j+1] <= sv_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sit_q[j+1]  <= sit_q[j];
        rem_q[j+1]  <= take ? rem_q[j] - trial : rem_q[j];
        root_q[j+1] <= take ? (root_q[j] | (SQ_BITS'(1) << K)) : root_q[j];
      end
    end
  end

  // Pitch uses the square root as the cosine term; a negative x starts at half a turn.
  assign pre_it = sit_q[SQ_BITS];
  assign pre_x  = (pre_it.op == OP_ASIN) ? CW'(root_q[SQ_BITS]) : CW'(pre_it.x);
  assign pre_y  = CW'(pre_it.y);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q[0] <= 1'b0;
    end else if (adv) begin
      cv_q[0] <= sv_q[SQ_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ct_q[0] <= '{op: pre_it.op, axis: pre_it.axis};
      if (pre_it.op == OP_CONST) begin
        cx_q[0] <= '0;
        cy_q[0] <= '0;
        cz_q[0] <= pre_it.z;
      end else if (pre_x < 0) begin
        cx_q[0] <= -pre_x;
        cy_q[0] <= -pre_y;
        cz_q[0] <= HALF_TURN;
      end else begin
        cx_q[0] <= pre_x;
        cy_q[0] <= pre_y;
        cz_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < N_STEPS; i++) begin : g_cordic
    localparam angle_t TAB = atan_tab(i);
    logic signed [CW-1:0] xs, ys;
    assign xs = cx_q[i] >>> i;
    assign ys = cy_q[i] >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_q[i+1] <= 1'b0;
      end else if (adv) begin
        cv_q[i+1] <= cv_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        ct_q[i+1] <= ct_q[i];
        if (ct_q[i].op == OP_CONST) begin
          cx_q[i+1] <= cx_q[i];
          cy_q[i+1] <= cy_q[i];
          cz_q[i+1] <= cz_q[i];
        end else if (cy_q[i] >= 0) begin
          cx_q[i+1] <= cx_q[i] + ys;
          cy_q[i+1] <= cy_q[i] - xs;
          cz_q[i+1] <= cz_q[i] + TAB;
        end else begin
          cx_q[i+1] <= cx_q[i] - ys;
          cy_q[i+1] <= cy_q[i] + xs;
          cz_q[i+1] <= cz_q[i] - TAB;
        end
      end
    end
  end

  // Reduce to 16 bits, subtract the axis offset, wrap modulo one turn.
  logic [ANGLE_BITS+16:0] wide;
  logic [15:0]            a16;
  logic [15:0]            res;

  assign wide = {1'b0, cz_q[N_STEPS], 16'b0} + TO16_RND;
  assign a16  = wide[ANGLE_BITS +: 16];

  always_comb begin
    case (ct_q[N_STEPS].axis)
      AXIS_ROLL:  res = a16 - offs_i.roll;
      AXIS_PITCH: res = a16 - offs_i.pitch;
      AXIS_YAW:   res = a16 - offs_i.yaw;
      default:    res = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= cv_q[N_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      angle_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign angle_o     = angle_q;

endmodule
`default_nettype wire

[src/quaternion_to_euler_wrapped_core.sv]
// Top level of the quaternion to Euler angle core with offset registers and wrap.
// Throughput: one transaction per cycle while the output is not stalled; the square root
// (one bit per stage) and the CORDIC (one step per stage) are fully pipelined, so every
// stage takes a new transaction each cycle unless the back end stalls.
// A four-entry queue separates the front end from the back end; the back end stalls as a whole.
// Reset is asynchronous and active low; it clears all valid flags and the offset registers.
`default_nettype none
module quaternion_to_euler_wrapped_core import qte_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [15:0] quat_w_i,
  input  wire logic signed [15:0] quat_x_i,
  input  wire logic signed [15:0] quat_y_i,
  input  wire logic signed [15:0] quat_z_i,
  input  wire logic [1:0]         axis_select_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [15:0]             angle_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  // The offset registers are written with a standard two-phase bus write.
  // Each one holds a binary angle that is subtracted from its own axis.
  offs_t offs_q;
  logic  wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offs_q <= '0;
    end else if (wr_en) begin
      case (reg_e'(paddr[3:2]))
        REG_ROLL:  offs_q.roll  <= pwdata[15:0];
        REG_PITCH: offs_q.pitch <= pwdata[15:0];
        REG_YAW:   offs_q.yaw   <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_e'(paddr[3:2]))
      REG_ROLL:  prdata = {16'b0, offs_q.roll};
      REG_PITCH: prdata = {16'b0, offs_q.pitch};
      REG_YAW:   prdata = {16'b0, offs_q.yaw};
      default:   prdata = '0;
    endcase
  end

  // The front end registers the four products of each transaction and then
  // classifies it: a normal atan2, an asin for pitch, or a constant answer for
  // the zero vector, a saturated pitch term or the unused selector code.
  logic             push;
  item_t            push_item;
  item_t            head;
  logic [CNT_W-1:0] q_cnt;
  logic             pop;

  qte_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .quat_w_i      (quat_w_i),
    .quat_x_i      (quat_x_i),
    .quat_y_i      (quat_y_i),
    .quat_z_i      (quat_z_i),
    .axis_select_i (axis_select_i),
    .q_cnt_i       (q_cnt),
    .push_o        (push),
    .item_o        (push_item)
  );

  qte_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .pop_i  (pop),
    .item_o (head),
    .cnt_o  (q_cnt)
  );

  // The back end computes the angle; its output register holds a finished result until it
  // is taken, and the front keeps accepting until the queue is full.
  qte_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .avail_i     (q_cnt != '0),
    .pop_o       (pop),
    .offs_i      (offs_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .angle_o     (angle_o)
  );

endmodule
`default_nettype wire

[bench/testbench.sv]
// Self-checking testbench for the quaternion to wrapped Euler angle core.
`timescale 1ns / 1ps
module testbench import qte_pkg::*; ();

  // Clock, reset and every input of the block start at known values.
  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [15:0] quat_w_i = '0;
  logic signed [15:0] quat_x_i = '0;
  logic signed [15:0] quat_y_i = '0;
  logic signed [15:0] quat_z_i = '0;
  logic [1:0]         axis_select_i = AXIS_ROLL;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [15:0]        angle_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  quaternion_to_euler_wrapped_core dut (.*);

  always #2 clk_i = ~clk_i;

  // The drain pause adds margin on top of the pipeline latency.
  localparam int DRAIN_CYCLES = 64;
  // Longest quiet stretch in a correct run: an output stall plus the pipeline latency,
  // or a drain pause. The limit takes that several times over.
  localparam int WATCHDOG_LIMIT = 2000;

  // Local copy of the offset registers, kept in step with each configuration write.
  logic [15:0] roll_off, pitch_off, yaw_off;
  // Angles still on their way through the block, oldest first.
  logic [15:0] angle_queue[$];
  int          mismatches = 0;
  int          sent_count = 0;
  int          got_count = 0;
  int          quiet_cycles = 0;

  // Arctangent of 2^-i, held at 2^32 units per turn.
  localparam logic [31:0] ATAN_TURN32 [16] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  // Vectoring CORDIC on a 16-bit binary angle; a zero vector gives zero.
  function automatic logic [15:0] vector_angle(longint y, longint x);
    logic [15:0] acc;
    logic [32:0] step_ang;
    longint xs, ys;
    acc = '0;
    if (x == 0 && y == 0) return '0;
    if (x < 0) begin
      acc = 16'h8000;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      step_ang = ({1'b0, ATAN_TURN32[i]} + 33'h8000) >> 16;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        acc = acc + step_ang[15:0];
      end else begin
        x = x - ys;
        y = y + xs;
        acc = acc - step_ang[15:0];
      end
    end
    return acc;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Expected wrapped angle for one quaternion and selector under the current offsets.
  function automatic logic [15:0] euler_angle(logic signed [15:0] qw, logic signed [15:0] qx,
                                              logic signed [15:0] qy, logic signed [15:0] qz,
                                              axis_e sel);
    longint w, x, y, z, s, c;
    logic [15:0] a;
    w = qw; x = qx; y = qy; z = qz;
    case (sel)
      AXIS_ROLL: begin
        a = vector_angle(2 * (w * x + y * z), (64'sd1 << 28) - 2 * (x * x + y * y));
        return a - roll_off;
      end
      AXIS_PITCH: begin
        s = 2 * (w * y - z * x);
        // Sine term at or beyond magnitude one clamps to a quarter turn of its own sign.
        if (s >= (64'sd1 << 28)) a = 16'd16384;
        else if (s <= -(64'sd1 << 28)) a = 16'd49152;
        else begin
          c = longint'(floor_sqrt(64'd1 << 56) * 0 + floor_sqrt((64'd1 << 56) - s * s));
          a = vector_angle(s, c);
        end
        return a - pitch_off;
      end
      AXIS_YAW: begin
        a = vector_angle(2 * (w * z + x * y), (64'sd1 << 28) - 2 * (z * z + y * y));
        return a - yaw_off;
      end
      default: return '0;
    endcase
  endfunction

  // Output side: ready bursts, short stalls and a few long ones.
  int ready_hold = 0;
  always @(posedge clk_i) begin
    int r;
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        out_ready_i <= 1'b1;
        ready_hold <= $urandom_range(0, 30);
      end else if (r < 92) begin
        out_ready_i <= 1'b0;
        ready_hold <= $urandom_range(0, 3);
      end else begin
        out_ready_i <= 1'b0;
        ready_hold <= $urandom_range(10, 40);
      end
    end
  end

  // Result checker: each accepted transaction is compared with the oldest expected angle.
  always @(posedge clk_i) begin
    logic [15:0] want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_count++;
      if (angle_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result angle=%0d", angle_o);
      end else begin
        want = angle_queue.pop_front();
        if (angle_o !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("angle mismatch: expected %0d, got %0d", want, angle_o);
        end
      end
    end
  end

  // Watchdog: cycles with no transaction on any channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", angle_queue.size());
      $display("FAIL");
      $finish;
    end
  end

  // Sends one quaternion and waits for its acceptance, then idles for a random gap.
  // Called at a rising edge; valid is only lowered when a gap follows.
  task automatic send_quat(logic signed [15:0] qw, logic signed [15:0] qx,
                           logic signed [15:0] qy, logic signed [15:0] qz, axis_e sel);
    int r, gap;
    in_valid_i <= 1'b1;
    quat_w_i <= qw;
    quat_x_i <= qx;
    quat_y_i <= qy;
    quat_z_i <= qz;
    axis_select_i <= sel;
    do @(posedge clk_i); while (!in_ready_o);
    angle_queue.push_back(euler_angle(qw, qx, qy, qz, sel));
    sent_count++;
    r = $urandom_range(0, 99);
    if (r < 55) gap = 0;
    else if (r < 93) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stops sending, waits until every expected angle has come out, then lets the
  // pipeline settle.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (angle_queue.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Register write with a setup and an access phase; the local copy follows at the write edge.
  task automatic write_reg(logic [3:0] addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (addr)
      4 * REG_ROLL:  roll_off = data[15:0];
      4 * REG_PITCH: pitch_off = data[15:0];
      4 * REG_YAW:   yaw_off = data[15:0];
      default: ;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_offsets(logic [15:0] r, logic [15:0] p, logic [15:0] y);
    write_reg(4'(4 * REG_ROLL), {16'hFFFF, r});
    write_reg(4'(4 * REG_PITCH), {16'h0000, p});
    write_reg(4'(4 * REG_YAW), {16'($urandom_range(0, 65535)), y});
  endtask

  // Roughly unit quaternion with random direction, scaled to Q2.14.
  task automatic random_unit(output logic signed [15:0] q[4]);
    real c[4];
    real n;
    n = 0.0;
    for (int i = 0; i < 4; i++) begin
      c[i] = real'($urandom_range(0, 65535)) - 32768.0;
      n = n + c[i] * c[i];
    end
    if (n < 1.0) begin
      c[0] = 1.0;
      n = 1.0;
    end
    n = $sqrt(n);
    for (int i = 0; i < 4; i++) q[i] = 16'($rtoi(c[i] / n * 16384.0 + (c[i] < 0 ? -0.5 : 0.5)));
  endtask

  function automatic axis_e pick_axis();
    int r;
    r = $urandom_range(0, 99);
    if (r < 32) return AXIS_ROLL;
    if (r < 64) return AXIS_PITCH;
    if (r < 96) return AXIS_YAW;
    return AXIS_NONE;
  endfunction

  // Field extremes, every axis, pitch clamping, the all-zero quaternion and the unused selector.
  task automatic test_directed();
    axis_e sel;
    send_quat(16384, 0, 0, 0, AXIS_ROLL);
    send_quat(16384, 0, 0, 0, AXIS_PITCH);
    send_quat(16384, 0, 0, 0, AXIS_YAW);
    send_quat(0, 0, 0, 0, AXIS_PITCH);
    // All-zero quaternion: the sine term vanishes and the cosine term is one.
    send_quat(0, 0, 0, 0, AXIS_ROLL);
    send_quat(0, 0, 0, 0, AXIS_YAW);
    // Sine term just inside and beyond magnitude one, both signs.
    send_quat(11585, 0, 11585, 0, AXIS_PITCH);
    send_quat(11586, 0, 11586, 0, AXIS_PITCH);
    send_quat(11586, 0, -11586, 0, AXIS_PITCH);
    send_quat(16384, 0, 16384, 0, AXIS_PITCH);
    send_quat(-32768, -32768, 32767, 32767, AXIS_PITCH);
    send_quat(32767, 32767, 32767, 32767, AXIS_PITCH);
    // Half-turn start from a negative cosine term, and a cosine term just above zero.
    send_quat(0, 16384, 0, 0, AXIS_ROLL);
    send_quat(0, 0, 0, 16384, AXIS_YAW);
    send_quat(11585, -11585, 0, 0, AXIS_ROLL);
    send_quat(11585, 0, 0, -11585, AXIS_YAW);
    send_quat(-32768, -32768, -32768, -32768, AXIS_ROLL);
    send_quat(-32768, -32768, -32768, -32768, AXIS_YAW);
    send_quat(32767, -32768, 32767, -32768, AXIS_ROLL);
    send_quat(32767, -32768, 32767, -32768, AXIS_YAW);
    // The unused selector ignores the quaternion and every offset.
    send_quat(32767, 32767, -32768, 1, AXIS_NONE);
    send_quat(0, 0, 0, 0, AXIS_NONE);
    for (int a = 0; a < 3; a++) begin
      sel = axis_e'(a);
      send_quat(-1, 1, -1, 1, sel);
    end
  endtask

  // One block of random traffic: mostly unit quaternions, some raw words and near-limit pitch.
  task automatic test_random(int count);
    logic signed [15:0] q[4];
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        random_unit(q);
      end else if (r < 90) begin
        for (int i = 0; i < 4; i++) q[i] = 16'($urandom_range(0, 65535));
      end else begin
        // Pitch close to the clamp: w and y near 1/sqrt2, x and z small.
        q[0] = 16'(11585 + $urandom_range(0, 4) - 2);
        q[2] = 16'((($urandom_range(0, 1) == 1) ? 1 : -1) * (11585 + $urandom_range(0, 4) - 2));
        q[1] = 16'($urandom_range(0, 6) - 3);
        q[3] = 16'($urandom_range(0, 6) - 3);
      end
      send_quat(q[0], q[1], q[2], q[3], pick_axis());
    end
  endtask

  // Random traffic across several offset settings, the extremes among them.
  task automatic test_offsets();
    test_random(480);
    wait_drained();
    set_offsets(16'hFFFF, 16'hFFFF, 16'hFFFF);
    test_random(480);
    wait_drained();
    set_offsets(16'h8000, 16'h0001, 16'h4000);
    test_random(480);
    wait_drained();
    set_offsets(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                16'($urandom_range(0, 65535)));
    // An address past the last register is ignored.
    write_reg(4'd12, 32'h0000_1234);
  endtask

  // The sender holds off until the block has drained, then resumes.
  task automatic test_drain_pause();
    test_random(200);
    wait_drained();
    test_random(280);
  endtask

  initial begin
    roll_off = '0;
    pitch_off = '0;
    yaw_off = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    wait_drained();
    set_offsets(16'h1234, 16'hC000, 16'h0000);
    test_directed();
    wait_drained();
    set_offsets(16'h0000, 16'h0000, 16'h0000);
    test_offsets();
    test_drain_pause();
    in_valid_i <= 1'b0;
    wait_drained();
    $display("Sent %0d quaternions over roll, pitch, yaw and the unused selector,", sent_count);
    $display("checked %0d angles under five offset settings; %0d mismatches.",
             got_count, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
src/qte_pkg.sv
src/qte_front.sv
src/qte_queue.sv
src/qte_back.sv
src/quaternion_to_euler_wrapped_core.sv
bench/testbench.sv
